@@ rtl/fxp_pkg.sv @@
// Shared constants, codes and types of the fixed-timestep pacer.
`default_nettype none
package fxp_pkg;

  localparam int TIME_BITS     = 40;
  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  // integer quotient bits followed by fraction bits
  localparam int DIV_BITS   = TIME_BITS + FRACTION_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);
  localparam int MUL_CNT_W  = $clog2(COUNT_BITS + 1);
  localparam int CMP_BITS   = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
  localparam int CFG_DATA_W = TIME_BITS;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TIME_BITS-1:0]  STEP_LENGTH_RST = TIME_BITS'(16666667);
  localparam logic [COUNT_BITS-1:0] MAX_STEPS_RST   = COUNT_BITS'(4);
  localparam logic [TIME_BITS-1:0]  LAG_LIMIT_RST   = TIME_BITS'(250000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_LENGTH  = 2'd0,
    CFG_MAX_STEPS    = 2'd1,
    CFG_LAG_LIMIT    = 2'd2,
    CFG_UNPACED_MODE = 2'd3
  } fxp_cfg_e;

  typedef enum logic [0:0] {
    STATUS_OK           = 1'b0,
    STATUS_NEG_ELAPSED  = 1'b1
  } fxp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_DIV,
    S_TRIM,
    S_WAKE,
    S_DONE
  } fxp_state_e;

  // sequencing shared by the serial units
  typedef struct packed {
    logic load;
    logic run;
  } fxp_seq_t;

endpackage
`default_nettype wire

@@ rtl/fxp_serial_div.sv @@
// Restoring bit-serial divider: integer quotient, then fraction bits.
`default_nettype none
module fxp_serial_div import fxp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fxp_seq_t             seq_i,
  input  wire logic [TIME_BITS-1:0] dividend_i,
  input  wire logic [TIME_BITS-1:0] divisor_i,
  output logic [DIV_BITS-1:0]       quot_o,
  output logic [TIME_BITS-1:0]      rem_o,
  output logic                      done_o
);

  logic [DIV_BITS-1:0]  shreg_q;
  logic [TIME_BITS-1:0] part_q, part_d;
  logic [TIME_BITS-1:0] rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  // dividend bits leave at the top while quotient bits enter at the bottom
  assign trial  = {part_q, shreg_q[DIV_BITS-1]};
  assign diff   = trial - {1'b0, divisor_i};
  assign fits   = trial >= {1'b0, divisor_i};
  assign part_d = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (seq_i.load) begin
      cnt_q <= '0;
    end else if (seq_i.run) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_i.load) begin
      shreg_q <= {dividend_i, {FRACTION_BITS{1'b0}}};
      part_q  <= '0;
    end else if (seq_i.run) begin
      shreg_q <= {shreg_q[DIV_BITS-2:0], fits};
      part_q  <= part_d;
      if (cnt_q == DIV_CNT_W'(TIME_BITS - 1)) begin
        rem_q <= part_d;
      end
    end
  end

  assign quot_o = shreg_q;
  assign rem_o  = rem_q;
  assign done_o = seq_i.run && (cnt_q == DIV_CNT_W'(DIV_BITS - 1));

endmodule
`default_nettype wire

@@ rtl/fxp_serial_mul.sv @@
// Shift-add multiplier: step length times max step count, one count bit a cycle.
`default_nettype none
module fxp_serial_mul import fxp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fxp_seq_t              seq_i,
  input  wire logic [TIME_BITS-1:0]  step_i,
  input  wire logic [COUNT_BITS-1:0] count_i,
  output logic [TIME_BITS-1:0]       prod_o,
  output logic                       busy_o
);

  logic [TIME_BITS-1:0]  acc_q;
  logic [COUNT_BITS-1:0] mq_q;
  logic [MUL_CNT_W-1:0]  cnt_q;
  logic                  active;

  assign active = cnt_q != MUL_CNT_W'(COUNT_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= MUL_CNT_W'(COUNT_BITS);
    end else if (seq_i.load) begin
      cnt_q <= '0;
    end else if (seq_i.run && active) begin
      cnt_q <= cnt_q + MUL_CNT_W'(1);
    end
  end

  // product kept mod 2^TIME_BITS; only used when it does not exceed the lag
  always_ff @(posedge clk_i) begin
    if (seq_i.load) begin
      acc_q <= '0;
      mq_q  <= count_i;
    end else if (seq_i.run && active) begin
      acc_q <= {acc_q[TIME_BITS-2:0], 1'b0} + (mq_q[COUNT_BITS-1] ? step_i : '0);
      mq_q  <= {mq_q[COUNT_BITS-2:0], 1'b0};
    end
  end

  assign prod_o = acc_q;
  assign busy_o = active;

endmodule
`default_nettype wire

@@ rtl/fixed_timestep_pacer_unit.sv @@
// Realtime advance: S_CLAMP, S_DIV, S_TRIM, S_WAKE, S_DONE, then the output register.
// Unpaced mode and rejected negative input: S_DONE, then the output register.
// A new item is taken only once the last result has moved to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset: registers at their reset values, kept lag zero, no result pending.
`default_nettype none
module fixed_timestep_pacer_unit import fxp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [TIME_BITS:0]    elapsed_ns_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       status_o,
  output logic [COUNT_BITS-1:0]      steps_to_run_o,
  output logic [FRACTION_BITS-1:0]   blend_fraction_o,
  output logic [TIME_BITS-1:0]       remaining_lag_o,
  output logic [TIME_BITS-1:0]       discarded_lag_o,
  output logic [TIME_BITS-1:0]       wake_after_o,
  output logic                       wake_valid_o
);

  logic [TIME_BITS-1:0]  step_len_q;
  logic [COUNT_BITS-1:0] max_steps_q;
  logic [TIME_BITS-1:0]  lag_limit_q;
  logic                  unpaced_q;
  logic [TIME_BITS-1:0]  kept_q;

  fxp_state_e state_q, state_d;

  logic [TIME_BITS:0]    sum_q;
  logic [TIME_BITS-1:0]  lag_q;

  fxp_status_e            res_status_q;
  logic [COUNT_BITS-1:0]  res_steps_q;
  logic [FRACTION_BITS-1:0] res_frac_q;
  logic [TIME_BITS-1:0]   res_remain_q;
  logic [TIME_BITS-1:0]   res_drop_q;
  logic [TIME_BITS-1:0]   res_wake_q;
  logic                   res_wv_q;

  logic                   out_valid_q;
  fxp_status_e            out_status_q;
  logic [COUNT_BITS-1:0]  out_steps_q;
  logic [FRACTION_BITS-1:0] out_frac_q;
  logic [TIME_BITS-1:0]   out_remain_q;
  logic [TIME_BITS-1:0]   out_drop_q;
  logic [TIME_BITS-1:0]   out_wake_q;
  logic                   out_wv_q;

  fxp_seq_t               seq;
  logic                   in_accept;
  logic                   out_load;
  logic                   div_done;
  logic                   mul_busy;
  logic [DIV_BITS-1:0]    div_quot;
  logic [TIME_BITS-1:0]   div_rem;
  logic [TIME_BITS-1:0]   mul_prod;

  logic                   over;
  logic [TIME_BITS:0]     over_diff;
  logic [TIME_BITS-1:0]   drop_d;
  logic [TIME_BITS-1:0]   lag_d;

  logic [CMP_BITS-1:0]    quot_ext;
  logic                   below_max;
  logic [COUNT_BITS-1:0]  count_d;
  logic [TIME_BITS-1:0]   remain_d;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q  <= STEP_LENGTH_RST;
      max_steps_q <= MAX_STEPS_RST;
      lag_limit_q <= LAG_LIMIT_RST;
      unpaced_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (fxp_cfg_e'(cfg_index_i))
        CFG_STEP_LENGTH:  step_len_q  <= cfg_data_i[TIME_BITS-1:0];
        CFG_MAX_STEPS:    max_steps_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_LAG_LIMIT:    lag_limit_q <= cfg_data_i[TIME_BITS-1:0];
        CFG_UNPACED_MODE: unpaced_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- serial units ----------------
  fxp_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seq_i      (seq),
    .dividend_i (lag_d),
    .divisor_i  (step_len_q),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  fxp_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seq_i   (seq),
    .step_i  (step_len_q),
    .count_i (max_steps_q),
    .prod_o  (mul_prod),
    .busy_o  (mul_busy)
  );

  // ---------------- datapath logic ----------------
  assign in_accept = in_valid_i && !in_stall_o;

  // clamp at the lag limit; discarded part saturates at the field width
  assign over      = sum_q > {1'b0, lag_limit_q};
  assign over_diff = sum_q - {1'b0, lag_limit_q};
  assign drop_d    = !over ? '0 :
                     (over_diff[TIME_BITS] ? '1 : over_diff[TIME_BITS-1:0]);
  assign lag_d     = over ? lag_limit_q : sum_q[TIME_BITS-1:0];

  // a zero step length leaves an all-ones quotient, so the cap applies
  assign quot_ext  = CMP_BITS'(div_quot[DIV_BITS-1:FRACTION_BITS]);
  assign below_max = quot_ext < CMP_BITS'(max_steps_q);
  assign count_d   = below_max ? quot_ext[COUNT_BITS-1:0] : max_steps_q;
  assign remain_d  = below_max ? div_rem : lag_q - mul_prod;

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    seq        = '0;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (unpaced_q || elapsed_ns_i[TIME_BITS]) begin
            state_d = S_DONE;
          end else begin
            state_d = S_CLAMP;
          end
        end
      end
      S_CLAMP: begin
        seq.load = 1'b1;
        state_d  = S_DIV;
      end
      S_DIV: begin
        seq.run = 1'b1;
        if (div_done) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: state_d = S_WAKE;
      S_WAKE: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
    end else if (state_q == S_TRIM) begin
      kept_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sum_q        <= {1'b0, kept_q} + elapsed_ns_i;
      res_steps_q  <= unpaced_q ? max_steps_q : '0;
      res_frac_q   <= '0;
      res_remain_q <= '0;
      res_drop_q   <= '0;
      res_wake_q   <= '0;
      res_wv_q     <= 1'b0;
      // unpaced mode takes negative input as well
      res_status_q <= (!unpaced_q && elapsed_ns_i[TIME_BITS]) ? STATUS_NEG_ELAPSED :
                      STATUS_OK;
    end
    if (state_q == S_CLAMP) begin
      lag_q      <= lag_d;
      res_drop_q <= drop_d;
    end
    if (state_q == S_TRIM) begin
      res_steps_q  <= count_d;
      res_remain_q <= remain_d;
      res_frac_q   <= (step_len_q == '0) ? '0 : div_quot[FRACTION_BITS-1:0];
    end
    if (state_q == S_WAKE) begin
      res_wake_q <= (res_remain_q >= step_len_q) ? '0 : step_len_q - res_remain_q;
      res_wv_q   <= 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_steps_q  <= res_steps_q;
      out_frac_q   <= res_frac_q;
      out_remain_q <= res_remain_q;
      out_drop_q   <= res_drop_q;
      out_wake_q   <= res_wake_q;
      out_wv_q     <= res_wv_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign steps_to_run_o   = out_steps_q;
  assign blend_fraction_o = out_frac_q;
  assign remaining_lag_o  = out_remain_q;
  assign discarded_lag_o  = out_drop_q;
  assign wake_after_o     = out_wake_q;
  assign wake_valid_o     = out_wv_q;

  // ---------------- assertions ----------------
  a_one_beat_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("second beat taken while an item is in flight");

  a_mul_before_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIM) |-> !mul_busy)
    else $error("step product not ready when the quotient is");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_NEG_ELAPSED) |->
      (steps_to_run_o == '0 && !wake_valid_o && remaining_lag_o == '0))
    else $error("rejected beat carries nonzero fields");

  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> (state_q == S_TRIM))
    else $error("divider finished outside the division phase");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the fixed-timestep pacer unit.
`timescale 1ns / 1ps

typedef struct packed {
  fxp_pkg::fxp_status_e              status;
  logic [fxp_pkg::COUNT_BITS-1:0]    steps;
  logic [fxp_pkg::FRACTION_BITS-1:0] fraction;
  logic [fxp_pkg::TIME_BITS-1:0]     lag_left;
  logic [fxp_pkg::TIME_BITS-1:0]     lag_dropped;
  logic [fxp_pkg::TIME_BITS-1:0]     wake_wait;
  logic                              wake_ok;
} advance_result_t;

// Mirrors the pacer registers and kept lag; queues the result each advance must give.
class pacer_tracker;
  localparam logic [63:0] TIME_MAX = (64'd1 << fxp_pkg::TIME_BITS) - 64'd1;

  logic [fxp_pkg::TIME_BITS-1:0]  step_len;
  logic [fxp_pkg::COUNT_BITS-1:0] step_cap;
  logic [fxp_pkg::TIME_BITS-1:0]  lag_cap;
  logic                           unpaced;
  logic [fxp_pkg::TIME_BITS:0]    lag_kept;
  advance_result_t                pending_advances[$];
  int                             mismatches;

  function new();
    step_len   = fxp_pkg::STEP_LENGTH_RST;
    step_cap   = fxp_pkg::MAX_STEPS_RST;
    lag_cap    = fxp_pkg::LAG_LIMIT_RST;
    unpaced    = 1'b0;
    lag_kept   = '0;
    mismatches = 0;
  endfunction

  function void set_reg(fxp_pkg::fxp_cfg_e idx, logic [fxp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fxp_pkg::CFG_STEP_LENGTH:  step_len = data[fxp_pkg::TIME_BITS-1:0];
      fxp_pkg::CFG_MAX_STEPS:    step_cap = data[fxp_pkg::COUNT_BITS-1:0];
      fxp_pkg::CFG_LAG_LIMIT:    lag_cap = data[fxp_pkg::TIME_BITS-1:0];
      fxp_pkg::CFG_UNPACED_MODE: unpaced = data[0];
      default: ;
    endcase
  endfunction

  function void note_advance(logic [fxp_pkg::TIME_BITS:0] elapsed);
    advance_result_t r;
    logic [63:0] lag, dropped, quot, rem, count, wake, frac;
    r = '0;
    r.status = fxp_pkg::STATUS_OK;
    if (unpaced) begin
      // unpaced wins over the sign check
      r.steps = step_cap;
    end else if (elapsed[fxp_pkg::TIME_BITS]) begin
      r.status = fxp_pkg::STATUS_NEG_ELAPSED;
    end else begin
      lag = (64'(lag_kept) + 64'(elapsed)) & ((64'd1 << (fxp_pkg::TIME_BITS + 1)) - 64'd1);
      dropped = '0;
      if (lag > 64'(lag_cap)) begin
        dropped = lag - 64'(lag_cap);
        if (dropped > TIME_MAX) dropped = TIME_MAX;
        lag = 64'(lag_cap);
      end
      if (step_len == '0) begin
        // divide by zero: all-ones quotient, remainder is the lag
        quot = '1;
        rem  = lag;
        frac = '0;
      end else begin
        quot = lag / 64'(step_len);
        rem  = lag % 64'(step_len);
        frac = (rem << fxp_pkg::FRACTION_BITS) / 64'(step_len);
      end
      count = (quot < 64'(step_cap)) ? quot : 64'(step_cap);
      lag = lag - 64'(step_len) * count;
      lag_kept = lag[fxp_pkg::TIME_BITS:0];
      wake = (lag >= 64'(step_len)) ? 64'd0 : 64'(step_len) - lag;
      r.steps       = count[fxp_pkg::COUNT_BITS-1:0];
      r.fraction    = frac[fxp_pkg::FRACTION_BITS-1:0];
      r.lag_left    = lag[fxp_pkg::TIME_BITS-1:0];
      r.lag_dropped = dropped[fxp_pkg::TIME_BITS-1:0];
      r.wake_wait   = wake[fxp_pkg::TIME_BITS-1:0];
      r.wake_ok     = 1'b1;
    end
    pending_advances.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function void check_result(advance_result_t got);
    advance_result_t want;
    if (pending_advances.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result beat with nothing pending: %h", got);
      return;
    end
    want = pending_advances.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("steps_to_run", want.steps, got.steps);
    compare_field("blend_fraction", want.fraction, got.fraction);
    compare_field("remaining_lag", want.lag_left, got.lag_left);
    compare_field("discarded_lag", want.lag_dropped, got.lag_dropped);
    compare_field("wake_after", want.wake_wait, got.wake_wait);
    compare_field("wake_valid", want.wake_ok, got.wake_ok);
  endfunction
endclass

module tb_top;
  import fxp_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 70;
  localparam int PHASE_ITEMS     = 200;
  localparam logic [TIME_BITS-1:0] TIME_ALL = '1;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  fxp_cfg_e                cfg_index_i  = CFG_STEP_LENGTH;
  logic [CFG_DATA_W-1:0]   cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [TIME_BITS:0]      elapsed_ns_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic                    status_o;
  logic [COUNT_BITS-1:0]   steps_to_run_o;
  logic [FRACTION_BITS-1:0] blend_fraction_o;
  logic [TIME_BITS-1:0]    remaining_lag_o;
  logic [TIME_BITS-1:0]    discarded_lag_o;
  logic [TIME_BITS-1:0]    wake_after_o;
  logic                    wake_valid_o;

  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 0;
  int unsigned     quiet_cycles = 0;
  pacer_tracker    tracker;
  advance_result_t seen;

  fixed_timestep_pacer_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status      = fxp_status_e'(status_o);
      seen.steps       = steps_to_run_o;
      seen.fraction    = blend_fraction_o;
      seen.lag_left    = remaining_lag_o;
      seen.lag_dropped = discarded_lag_o;
      seen.wake_wait   = wake_after_o;
      seen.wake_ok     = wake_valid_o;
      tracker.check_result(seen);
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_advance(logic [TIME_BITS:0] elapsed);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elapsed_ns_i <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_advance(elapsed);
  endtask

  task automatic write_reg(fxp_cfg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  // every advance yields a result, so an empty queue means the block is idle
  task automatic program_regs(logic [TIME_BITS-1:0] step, logic [COUNT_BITS-1:0] cap,
                              logic [TIME_BITS-1:0] limit, logic unp);
    in_valid_i <= 1'b0;
    while (tracker.pending_advances.size() != 0) @(posedge clk_i);
    write_reg(CFG_STEP_LENGTH, step);
    write_reg(CFG_MAX_STEPS, CFG_DATA_W'(cap));
    write_reg(CFG_LAG_LIMIT, limit);
    write_reg(CFG_UNPACED_MODE, CFG_DATA_W'(unp));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TIME_BITS:0] pick_elapsed(logic [TIME_BITS-1:0] step);
    logic [63:0] raw, span, pick;
    int unsigned kind;
    raw  = {$urandom, $urandom};
    kind = $urandom_range(99);
    span = (step == '0) ? 64'd1000 : 64'(step);
    if (kind < 10) begin
      pick = 64'({1'b1, raw[TIME_BITS-1:0]});    // rejected, negative
    end else if (kind < 16) begin
      pick = '0;
    end else if (kind < 28) begin
      pick = 64'({1'b0, raw[TIME_BITS-1:0]});
    end else if (kind < 65) begin
      pick = raw % (span + 64'd1);               // within one step
    end else if (kind < 90) begin
      pick = raw % (span * 64'd5 + 64'd1);       // a few steps' worth
      if (pick > 64'(TIME_ALL)) pick = 64'(TIME_ALL);
    end else begin
      pick = raw % 64'd16;
    end
    return pick[TIME_BITS:0];
  endfunction

  task automatic run_phase(int unsigned gap, int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (PHASE_ITEMS) send_advance(pick_elapsed(tracker.step_len));
  endtask

  initial begin
    logic [TIME_BITS-1:0] s;
    int unsigned gaps[4];
    int unsigned stalls[4];
    gaps   = '{0, 45, 0, 38};
    stalls = '{0, 0, 45, 38};
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: below, at and past one step, clamp, negatives
    send_advance(0);
    send_advance(16666666);
    send_advance(16666667);
    send_advance(100000000);
    send_advance({1'b0, TIME_ALL});
    send_advance('1);
    send_advance({1'b1, {TIME_BITS{1'b0}}});
    // zero step length
    program_regs('0, 7, TIME_ALL, 1'b0);
    send_advance(12345);
    send_advance({1'b0, TIME_ALL});
    // widest step; leaves a kept lag near full scale
    program_regs(TIME_ALL, '1, TIME_ALL, 1'b0);
    send_advance(1);
    send_advance({1'b0, TIME_ALL - 1'b1});
    // lowered limit with zero cap: discarded lag saturates
    program_regs(1, '0, 1, 1'b0);
    send_advance({1'b0, TIME_ALL});
    send_advance(0);
    // unpaced, negative included
    program_regs(16666667, '1, 250000000, 1'b1);
    send_advance('1);
    send_advance(0);
    send_advance({1'b0, TIME_ALL});
    // limit below one step
    program_regs(1000, 1, 999, 1'b0);
    send_advance(5000);
    send_advance(3);

    for (int ph = 0; ph < 9; ph++) begin
      s = TIME_BITS'($urandom_range(1, 1 << 20));
      case (ph)
        0: program_regs(16666667, 4, 250000000, 1'b0);
        1: program_regs(1000, 3, 10000, 1'b0);
        2: program_regs(s, COUNT_BITS'($urandom_range(1, 8)),
                        s * TIME_BITS'($urandom_range(1, 20)), 1'b0);
        3: program_regs(TIME_ALL, '1, TIME_ALL, 1'b0);
        4: program_regs(1, '1, TIME_ALL, 1'b0);
        5: program_regs(s, COUNT_BITS'($urandom_range(0, 65535)),
                        TIME_BITS'({$urandom, $urandom}), 1'b1);
        6: program_regs(7, 2, 100, 1'b0);
        7: program_regs(TIME_BITS'({$urandom, $urandom}), COUNT_BITS'($urandom_range(0, 65535)),
                        TIME_BITS'({$urandom, $urandom}), 1'b0);
        default: program_regs('0, COUNT_BITS'($urandom_range(0, 65535)),
                              TIME_BITS'({$urandom, $urandom}), 1'b0);
      endcase
      run_phase(gaps[ph % 4], stalls[ph % 4]);
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_advances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_advances.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
rtl/fxp_pkg.sv
rtl/fxp_serial_div.sv
rtl/fxp_serial_mul.sv
rtl/fixed_timestep_pacer_unit.sv
bench/tb_top.sv
